// ----- hw/rtl/ip_activity_bitmap_macros.svh -----
// Assertion helpers for the activity bitmap block.
`ifndef IP_ACTIVITY_BITMAP_MACROS_SVH
`define IP_ACTIVITY_BITMAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abm assertion failed");

// Next-cycle implication, disabled during reset.
`define ABM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abm assertion failed");

`endif

// ----- hw/rtl/abm_pkg.sv -----
`default_nettype none
package abm_pkg;

   localparam int MAP_BITS    = 1024;
   localparam int MAP_WORDS   = MAP_BITS / 64;
   localparam int IDX_W       = $clog2(MAP_BITS);
   localparam int WORD_W      = (IDX_W > 6) ? IDX_W - 6 : 1;
   localparam int SIZE_W      = IDX_W + 1;
   localparam int WCNT_W      = WORD_W + 1;
   localparam int WORD_IDX_W  = 4;
   localparam int ROW_W       = 10;
   localparam int CSR_IDX_W   = 3;

   localparam logic [SIZE_W-1:0] MAP_SIZE_MAX = SIZE_W'(MAP_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RANGE_FIRST = 3'd0,
      REG_RANGE_LAST  = 3'd1,
      REG_PREFIX_LEN  = 3'd2,
      REG_INTERVAL    = 3'd3,
      REG_WINDOW_ROWS = 3'd4
   } abm_reg_type;

   typedef enum logic [1:0] {
      SEL_SRC  = 2'd0,
      SEL_DST  = 2'd1,
      SEL_BOTH = 2'd2
   } abm_sel_type;

   localparam logic KIND_FLOW = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic eval;
      logic mod_start;
      logic flush_init;
      logic rd_flush;
      logic out_load;
      logic clear;
      logic advance;
      logic rd_src;
      logic wr_src;
      logic rd_dst;
      logic wr_dst;
   } abm_cmd_type;

   typedef struct packed {
      logic flush_req;
      logic is_end;
      logic no_words;
      logic last_word;
      logic mod_done;
      logic out_free;
   } abm_sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ip_activity_bitmap.sv -----
// IPv4 activity bitmap.
// req_ channel: one request per flow record (kind 0) or end-of-stream flush
//   (kind 1), taken when req_valid and req_ready are high at a clock edge.
// rsp_ channel: map words, source map first, then destination, then combined,
//   each tagged with row and word index; rsp_last marks the final word.
// csr_ channel: register writes, always ready; the user writes only while no
//   request is open, which the block itself does not enforce.
// A record that does not close an interval goes through prep and eval, then
//   two read-modify-writes of map words (source entry, then destination
//   entry) through one port per map memory, before the next accept.
// A flush finds the row number (a one-bit-per-cycle remainder unit), emits
//   up to 48 words (memory read, then output load), then clears the maps.
// The output register holds a word while rsp_ready is low; the flush walk
//   stalls until the word is taken, then goes on.
// Reset restores the register defaults, empties all maps through their word
//   valid bits at once and forgets the interval state; no clearing pass.
`default_nettype none
module ip_activity_bitmap
   import abm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_kind,
   input  wire logic [31:0]          req_src_addr,
   input  wire logic [31:0]          req_dst_addr,
   input  wire logic [31:0]          req_seconds,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_map_select,
   output logic [ROW_W-1:0]          rsp_row,
   output logic [WORD_IDX_W-1:0]     rsp_word_index,
   output logic [63:0]               rsp_word_bits,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   abm_cmd_type      cmd;
   abm_sts_type      sts;
   logic             mod_start, mod_done;
   logic [31:0]      mod_dividend;
   logic [ROW_W-1:0] mod_divisor, mod_rem;

   // registers are plain flops, writes always land
   assign csr_ready = 1'b1;

   // sequence each request: prep, eval, optional flush walk, map updates for flow records
   abm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold config, interval state, map memories and the output register
   abm_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_src_addr   (req_src_addr),
      .req_dst_addr   (req_dst_addr),
      .req_seconds    (req_seconds),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mod_start      (mod_start),
      .mod_dividend   (mod_dividend),
      .mod_divisor    (mod_divisor),
      .mod_done       (mod_done),
      .mod_rem        (mod_rem),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_map_select (rsp_map_select),
      .rsp_row        (rsp_row),
      .rsp_word_index (rsp_word_index),
      .rsp_word_bits  (rsp_word_bits),
      .rsp_last       (rsp_last)
   );

   // row number: interval count modulo window rows
   abm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/abm_mod.sv -----
`default_nettype none
module abm_mod
   import abm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [31:0]       dividend,
   input  wire logic [ROW_W-1:0]  divisor,
   output logic                   done,
   output logic [ROW_W-1:0]       remainder
);

   logic [31:0]      dvd_ff, dvd_in;
   logic [ROW_W-1:0] rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ROW_W:0]   part;

   // one quotient bit per cycle, remainder only
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      part    = {rem_ff, dvd_ff[31]};
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (part >= {1'b0, divisor}) begin
            rem_in = ROW_W'(part - {1'b0, divisor});
         end else begin
            rem_in = ROW_W'(part);
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/abm_ctrl.sv -----
`default_nettype none
module abm_ctrl
   import abm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire abm_sts_type sts,
   output abm_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_EVAL, S_MOD, S_FRD, S_FOUT, S_CLEAR,
      S_SRC_RD, S_SRC_WR, S_DST_RD, S_DST_WR
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.flush_req) begin
               cmd.mod_start = 1'b1;
               state_in      = S_MOD;
            end else begin
               state_in = S_SRC_RD;
            end
         end
         S_MOD: begin
            if (sts.mod_done) begin
               cmd.flush_init = 1'b1;
               state_in       = sts.no_words ? S_CLEAR : S_FRD;
            end
         end
         S_FRD: begin
            cmd.rd_flush = 1'b1;
            state_in     = S_FOUT;
         end
         S_FOUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.last_word ? S_CLEAR : S_FRD;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.is_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_SRC_RD;
            end
         end
         S_SRC_RD: begin
            cmd.rd_src = 1'b1;
            state_in   = S_SRC_WR;
         end
         S_SRC_WR: begin
            cmd.wr_src = 1'b1;
            state_in   = S_DST_RD;
         end
         S_DST_RD: begin
            cmd.rd_dst = 1'b1;
            state_in   = S_DST_WR;
         end
         S_DST_WR: begin
            cmd.wr_dst = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/abm_dpath.sv -----
`default_nettype none
module abm_dpath
   import abm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abm_cmd_type           cmd,
   output abm_sts_type                sts,
   input  wire logic                  req_kind,
   input  wire logic [31:0]           req_src_addr,
   input  wire logic [31:0]           req_dst_addr,
   input  wire logic [31:0]           req_seconds,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_wdata,
   output logic                       mod_start,
   output logic [31:0]                mod_dividend,
   output logic [ROW_W-1:0]           mod_divisor,
   input  wire logic                  mod_done,
   input  wire logic [ROW_W-1:0]      mod_rem,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_map_select,
   output logic [ROW_W-1:0]           rsp_row,
   output logic [WORD_IDX_W-1:0]      rsp_word_index,
   output logic [63:0]                rsp_word_bits,
   output logic                       rsp_last
);

   // configuration
   logic [31:0]      first_ff, last_ff, isec_ff;
   logic [5:0]       plen_ff;
   logic [ROW_W-1:0] win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 32'h0100_0000;
         last_ff  <= 32'hFF00_0000;
         plen_ff  <= 6'd8;
         isec_ff  <= 32'd300;
         win_ff   <= 10'd100;
      end else if (csr_valid) begin
         unique case (abm_reg_type'(csr_index))
            REG_RANGE_FIRST: first_ff <= csr_wdata;
            REG_RANGE_LAST:  last_ff  <= csr_wdata;
            REG_PREFIX_LEN:  plen_ff  <= csr_wdata[5:0];
            REG_INTERVAL:    isec_ff  <= csr_wdata;
            REG_WINDOW_ROWS: win_ff   <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // request and interval state
   logic        kind_ff;
   logic [31:0] src_ff, dst_ff, secs_ff;
   logic        seen_ff;
   logic [31:0] istart_ff, icount_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         src_ff  <= req_src_addr;
         dst_ff  <= req_dst_addr;
         secs_ff <= req_seconds;
      end
   end

   // prep stage: shifts and interval compare
   logic [5:0]  plen_c, shamt;
   logic [31:0] f_sh_ff, l_sh_ff, s_sh_ff, d_sh_ff;
   logic        late_ff;

   assign plen_c = (plen_ff > 6'd32) ? 6'd32 : plen_ff;
   assign shamt  = 6'd32 - plen_c;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         f_sh_ff <= first_ff >> shamt;
         l_sh_ff <= last_ff >> shamt;
         s_sh_ff <= src_ff >> shamt;
         d_sh_ff <= dst_ff >> shamt;
         late_ff <= ({1'b0, istart_ff} + {1'b0, isec_ff}) < {1'b0, secs_ff};
      end
   end

   // eval stage: map size and entry positions
   logic [31:0]       diff, s_off, d_off;
   logic [SIZE_W-1:0] size_c;
   logic [SIZE_W:0]   words_wide;
   logic              s_hit_c, d_hit_c;
   logic [WCNT_W-1:0] words_ff;
   logic [5:0]        size_lo_ff;
   logic              s_hit_ff, d_hit_ff;
   logic [IDX_W-1:0]  s_idx_ff, d_idx_ff;

   always_comb begin
      diff  = l_sh_ff - f_sh_ff;
      s_off = s_sh_ff - f_sh_ff;
      d_off = d_sh_ff - f_sh_ff;
      if (f_sh_ff > l_sh_ff) begin
         size_c = '0;
      end else if (diff >= 32'(MAP_BITS - 1)) begin
         size_c = MAP_SIZE_MAX;
      end else begin
         size_c = SIZE_W'(diff) + SIZE_W'(1);
      end
      words_wide = ({1'b0, size_c} + (SIZE_W + 1)'(63)) >> 6;
      s_hit_c = (s_sh_ff >= f_sh_ff) && (s_sh_ff <= l_sh_ff) && (s_off < 32'(MAP_BITS));
      d_hit_c = (d_sh_ff >= f_sh_ff) && (d_sh_ff <= l_sh_ff) && (d_off < 32'(MAP_BITS));
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         words_ff   <= WCNT_W'(words_wide);
         size_lo_ff <= size_c[5:0];
         s_hit_ff   <= s_hit_c;
         d_hit_ff   <= d_hit_c;
         s_idx_ff   <= s_off[IDX_W-1:0];
         d_idx_ff   <= d_off[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= 1'b0;
         istart_ff <= '0;
         icount_ff <= '0;
      end else if (cmd.eval && (kind_ff == KIND_FLOW) && !seen_ff) begin
         seen_ff   <= 1'b1;
         istart_ff <= secs_ff;
      end else if (cmd.advance) begin
         istart_ff <= istart_ff + isec_ff;
         icount_ff <= icount_ff + 32'd1;
      end
   end

   assign mod_start    = cmd.mod_start;
   assign mod_dividend = icount_ff;
   assign mod_divisor  = (win_ff == '0) ? ROW_W'(1) : win_ff;

   // map memories with per-word valid bits
   logic [63:0]         src_mem  [MAP_WORDS];
   logic [63:0]         dst_mem  [MAP_WORDS];
   logic [63:0]         both_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] src_vld_ff, dst_vld_ff, both_vld_ff;
   logic [63:0]         src_rd_ff, dst_rd_ff, both_rd_ff;
   logic                src_rv_ff, dst_rv_ff, both_rv_ff;
   logic [WORD_W-1:0]   rd_addr, wr_addr_ff;
   logic                rd_en;
   logic [1:0]          fsel_ff;
   logic [WORD_W-1:0]   fword_ff;
   logic [63:0]         src_eff, dst_eff, both_eff;
   logic [63:0]         s_bit, d_bit;
   logic                wr_s, wr_d, wr_b;
   logic [63:0]         wr_s_data, wr_d_data, wr_b_data;

   always_comb begin
      rd_en = cmd.rd_flush || cmd.rd_src || cmd.rd_dst;
      if (cmd.rd_src) begin
         rd_addr = s_idx_ff[IDX_W-1:6];
      end else if (cmd.rd_dst) begin
         rd_addr = d_idx_ff[IDX_W-1:6];
      end else begin
         rd_addr = fword_ff;
      end
      src_eff  = src_rv_ff  ? src_rd_ff  : '0;
      dst_eff  = dst_rv_ff  ? dst_rd_ff  : '0;
      both_eff = both_rv_ff ? both_rd_ff : '0;
      s_bit    = 64'h8000_0000_0000_0000 >> s_idx_ff[5:0];
      d_bit    = 64'h8000_0000_0000_0000 >> d_idx_ff[5:0];
      wr_s      = cmd.wr_src && s_hit_ff;
      wr_d      = cmd.wr_dst && d_hit_ff;
      wr_b      = wr_s || wr_d;
      wr_s_data = src_eff | s_bit;
      wr_d_data = dst_eff | d_bit;
      wr_b_data = both_eff | (cmd.wr_src ? s_bit : d_bit);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         src_rd_ff  <= src_mem[rd_addr];
         dst_rd_ff  <= dst_mem[rd_addr];
         both_rd_ff <= both_mem[rd_addr];
         src_rv_ff  <= src_vld_ff[rd_addr];
         dst_rv_ff  <= dst_vld_ff[rd_addr];
         both_rv_ff <= both_vld_ff[rd_addr];
         wr_addr_ff <= rd_addr;
      end
      if (wr_s) begin
         src_mem[wr_addr_ff] <= wr_s_data;
      end
      if (wr_d) begin
         dst_mem[wr_addr_ff] <= wr_d_data;
      end
      if (wr_b) begin
         both_mem[wr_addr_ff] <= wr_b_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         src_vld_ff  <= '0;
         dst_vld_ff  <= '0;
         both_vld_ff <= '0;
      end else begin
         if (wr_s) begin
            src_vld_ff[wr_addr_ff] <= 1'b1;
         end
         if (wr_d) begin
            dst_vld_ff[wr_addr_ff] <= 1'b1;
         end
         if (wr_b) begin
            both_vld_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   // flush walk and output register
   logic              word_last, flush_last;
   logic [63:0]       sel_bits, out_bits;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_sel_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [63:0]       rsp_bits_ff;
   logic              rsp_last_ff;

   always_comb begin
      word_last  = ({1'b0, fword_ff} == (words_ff - WCNT_W'(1)));
      flush_last = word_last && (fsel_ff == SEL_BOTH);
      case (abm_sel_type'(fsel_ff))
         SEL_SRC:  sel_bits = src_eff;
         SEL_DST:  sel_bits = dst_eff;
         default:  sel_bits = both_eff;
      endcase
      if (word_last && (size_lo_ff != 6'd0)) begin
         out_bits = sel_bits & ~({64{1'b1}} >> size_lo_ff);
      end else begin
         out_bits = sel_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flush_init) begin
         fsel_ff  <= SEL_SRC;
         fword_ff <= '0;
      end else if (cmd.out_load) begin
         if (word_last) begin
            fsel_ff  <= fsel_ff + 2'd1;
            fword_ff <= '0;
         end else begin
            fword_ff <= fword_ff + WORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sel_ff  <= fsel_ff;
         rsp_row_ff  <= mod_rem;
         rsp_word_ff <= fword_ff;
         rsp_bits_ff <= out_bits;
         rsp_last_ff <= flush_last;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.flush_req = (kind_ff == KIND_END) || (seen_ff && late_ff);
   assign sts.is_end    = (kind_ff == KIND_END);
   assign sts.no_words  = (words_ff == '0);
   assign sts.last_word = flush_last;
   assign sts.mod_done  = mod_done;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_map_select = rsp_sel_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_word_index = WORD_IDX_W'(rsp_word_ff);
   assign rsp_word_bits  = rsp_bits_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/abm_checker.sv -----
`default_nettype none
`include "ip_activity_bitmap_macros.svh"
module abm_checker
   import abm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_kind,
   input  wire logic [31:0]          req_src_addr,
   input  wire logic [31:0]          req_dst_addr,
   input  wire logic [31:0]          req_seconds,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [1:0]           rsp_map_select,
   input  wire logic [ROW_W-1:0]     rsp_row,
   input  wire logic [WORD_IDX_W-1:0] rsp_word_index,
   input  wire logic [63:0]          rsp_word_bits,
   input  wire logic                 rsp_last,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   // hold a word while stalled
   `ABM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // only the combined map ends a flush
   `ABM_ASSERT_IMP(a_last_both, clock, reset, rsp_valid && rsp_last, rsp_map_select == SEL_BOTH)
   // no new request while a flush is still walking
   `ABM_ASSERT_IMP(a_busy_flush, clock, reset, rsp_valid && !rsp_last, !req_ready)
   // no select code past the combined map leaves the block
   `ABM_ASSERT_IMP(a_sel_range, clock, reset, rsp_valid, rsp_map_select <= SEL_BOTH)

endmodule

bind ip_activity_bitmap abm_checker u_abm_checker (.*);
`default_nettype wire

// ----- dv/ip_activity_bitmap_checker.sv -----
`timescale 1ns / 1ps
module ip_activity_bitmap_checker
   import abm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_kind,
   input  wire logic [31:0]          req_src_addr,
   input  wire logic [31:0]          req_dst_addr,
   input  wire logic [31:0]          req_seconds,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [1:0]           rsp_map_select,
   input  wire logic [ROW_W-1:0]     rsp_row,
   input  wire logic [WORD_IDX_W-1:0] rsp_word_index,
   input  wire logic [63:0]          rsp_word_bits,
   input  wire logic                 rsp_last,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output int                        mismatch_count,
   output int                        words_due
);

   typedef struct packed {
      logic [1:0]            map_select;
      logic [ROW_W-1:0]      row;
      logic [WORD_IDX_W-1:0] word_index;
      logic [63:0]           word_bits;
      logic                  last;
   } map_word_type;

   map_word_type expected_words[$];

   logic [31:0] cfg_first, cfg_last, cfg_interval;
   logic [5:0]  cfg_prefix;
   logic [9:0]  cfg_window;

   logic [63:0] src_bits  [MAP_WORDS];
   logic [63:0] dst_bits  [MAP_WORDS];
   logic [63:0] both_bits [MAP_WORDS];
   logic        started;
   logic [31:0] start_sec;
   logic [31:0] interval_cnt;

   int errs = 0;

   initial begin
      mismatch_count = 0;
      words_due      = 0;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      errs++;
   endtask

   task automatic clear_maps();
      for (int i = 0; i < MAP_WORDS; i++) begin
         src_bits[i]  = '0;
         dst_bits[i]  = '0;
         both_bits[i] = '0;
      end
   endtask

   // Network part of an address; a prefix above 32 counts as 32.
   function automatic logic [31:0] net_of(input logic [31:0] addr);
      int unsigned sh;
      sh = 32 - ((cfg_prefix > 6'd32) ? 32 : int'(cfg_prefix));
      return 32'({32'd0, addr} >> sh);
   endfunction

   function automatic int unsigned entries_in_use();
      logic [31:0] f, l;
      logic [32:0] n;
      f = net_of(cfg_first);
      l = net_of(cfg_last);
      if (f > l) return 0;
      n = {1'b0, l} - {1'b0, f} + 33'd1;
      if (n > MAP_BITS) n = MAP_BITS;
      return int'(n);
   endfunction

   task automatic record_address(input bit to_dst, input logic [31:0] addr);
      logic [31:0] f, l, a, idx;
      logic [63:0] one_hot;
      f = net_of(cfg_first);
      l = net_of(cfg_last);
      a = net_of(addr);
      if (a < f || a > l) return;
      idx = a - f;
      if (idx >= MAP_BITS) return;
      one_hot = 64'd1 << (63 - idx[5:0]);
      if (to_dst) dst_bits[idx[IDX_W-1:6]] |= one_hot;
      else src_bits[idx[IDX_W-1:6]] |= one_hot;
      both_bits[idx[IDX_W-1:6]] |= one_hot;
   endtask

   // Queue every word of the three maps for the current row, then drop the maps.
   task automatic emit_maps();
      int unsigned size, words, win, valid;
      logic [63:0] bits;
      map_word_type w;
      size  = entries_in_use();
      words = (size + 63) / 64;
      win   = (cfg_window == 10'd0) ? 1 : int'(cfg_window);
      for (int m = 0; m < 3; m++) begin
         for (int i = 0; i < int'(words); i++) begin
            case (m)
               0: begin
                  bits = src_bits[i];
                  w.map_select = SEL_SRC;
               end
               1: begin
                  bits = dst_bits[i];
                  w.map_select = SEL_DST;
               end
               default: begin
                  bits = both_bits[i];
                  w.map_select = SEL_BOTH;
               end
            endcase
            valid = size - i * 64;
            if (valid < 64) bits &= ~(~64'd0 >> valid);
            w.row        = ROW_W'(interval_cnt % win);
            w.word_index = WORD_IDX_W'(i);
            w.word_bits  = bits;
            w.last       = (w.map_select == SEL_BOTH) && (i + 1 == int'(words));
            expected_words.push_back(w);
         end
      end
      clear_maps();
   endtask

   task automatic apply_request(input logic kind, input logic [31:0] src,
                                input logic [31:0] dst, input logic [31:0] secs);
      if (kind == KIND_END) begin
         emit_maps();
         return;
      end
      if (!started) begin
         start_sec = secs;
         started   = 1'b1;
      end else if ({1'b0, start_sec} + {1'b0, cfg_interval} < {1'b0, secs}) begin
         emit_maps();
         start_sec    = start_sec + cfg_interval;
         interval_cnt = interval_cnt + 32'd1;
      end
      record_address(1'b0, src);
      record_address(1'b1, dst);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
         REG_RANGE_FIRST: cfg_first    = data;
         REG_RANGE_LAST:  cfg_last     = data;
         REG_PREFIX_LEN:  cfg_prefix   = data[5:0];
         REG_INTERVAL:    cfg_interval = data;
         REG_WINDOW_ROWS: cfg_window   = data[9:0];
         default: ;
      endcase
   endtask

   task automatic check_word();
      map_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected word", rsp_word_bits, '0);
         return;
      end
      want = expected_words.pop_front();
      if (rsp_map_select !== want.map_select)
         report_mismatch("map_select", rsp_map_select, want.map_select);
      if (rsp_row !== want.row)
         report_mismatch("row", rsp_row, want.row);
      if (rsp_word_index !== want.word_index)
         report_mismatch("word_index", rsp_word_index, want.word_index);
      if (rsp_word_bits !== want.word_bits)
         report_mismatch("word_bits", rsp_word_bits, want.word_bits);
      if (rsp_last !== want.last)
         report_mismatch("last", rsp_last, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_first    = 32'h0100_0000;
         cfg_last     = 32'hFF00_0000;
         cfg_prefix   = 6'd8;
         cfg_interval = 32'd300;
         cfg_window   = 10'd100;
         clear_maps();
         started      = 1'b0;
         start_sec    = '0;
         interval_cnt = '0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            apply_request(req_kind, req_src_addr, req_dst_addr, req_seconds);
         if (rsp_valid && rsp_ready) check_word();
      end
      mismatch_count <= errs;
      words_due      <= expected_words.size();
   end

endmodule

// ----- dv/ip_activity_bitmap_tb.sv -----
`timescale 1ns / 1ps
module ip_activity_bitmap_tb;
   import abm_pkg::*;

   // Idle cycles to wait once all words are back: a flush with an empty map
   // still spends the remainder unit and the clear cycle.
   localparam int SETTLE_CYCLES = 100;
   // Cycles with no handshake on any channel before the run is declared hung.
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ROUNDS = 4;
   localparam int ROUND_ITEMS   = 38;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd5;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_kind;
   logic [31:0]           req_src_addr;
   logic [31:0]           req_dst_addr;
   logic [31:0]           req_seconds;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_map_select;
   logic [ROW_W-1:0]      rsp_row;
   logic [WORD_IDX_W-1:0] rsp_word_index;
   logic [63:0]           rsp_word_bits;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [31:0]           csr_wdata;

   int mismatch_count;
   int words_due;
   int quiet_cycles;
   int rsp_hold;

   // Per-round switches that turn off idling on one side.
   bit req_steady;
   bit rsp_steady;

   // Shape of the current watched range, kept for address picking.
   logic [63:0] lo_net, hi_net, net_max;
   int unsigned net_shift;
   logic [31:0] tb_now, time_step;

   ip_activity_bitmap DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_src_addr   (req_src_addr),
      .req_dst_addr   (req_dst_addr),
      .req_seconds    (req_seconds),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_map_select (rsp_map_select),
      .rsp_row        (rsp_row),
      .rsp_word_index (rsp_word_index),
      .rsp_word_bits  (rsp_word_bits),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ip_activity_bitmap_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_src_addr   (req_src_addr),
      .req_dst_addr   (req_dst_addr),
      .req_seconds    (req_seconds),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_map_select (rsp_map_select),
      .rsp_row        (rsp_row),
      .rsp_word_index (rsp_word_index),
      .rsp_word_bits  (rsp_word_bits),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Throttle the result side: drop ready for a random stretch, then raise it.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 3) == 0) rsp_hold <= idle_len();
      end
   end

   // Watchdog: end the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Raise a request and hold it until taken. Valid stays high on return so a
   // back-to-back request never lowers and raises it in the same step.
   task automatic send_request(input logic kind, input logic [31:0] src,
                               input logic [31:0] dst, input logic [31:0] secs);
      req_kind     <= kind;
      req_src_addr <= src;
      req_dst_addr <= dst;
      req_seconds  <= secs;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Register write; the caller drops csr_valid after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Random gap between requests, skipped in steady rounds.
   task automatic idle_req();
      int n;
      n = req_steady ? 0 : idle_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every queued word has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   // Drain, then let the block finish any flush that emits nothing.
   task automatic settle();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Address near or inside the watched range, with a share of pure noise.
   function automatic logic [31:0] pick_addr();
      logic [63:0] off, n;
      if ($urandom_range(0, 9) < 2) return $urandom();
      off = {32'd0, $urandom()} % (hi_net - lo_net + 64'd3);
      if (off == 0) n = (lo_net == 0) ? 64'd0 : lo_net - 64'd1;
      else n = lo_net + off - 64'd1;
      if (n > net_max) n = net_max;
      return 32'((n << net_shift) | ({32'd0, $urandom()} & ((64'd1 << net_shift) - 64'd1)));
   endfunction

   // Pick and program a random setting; a wide one nearly fills, fills or overruns the map.
   task automatic random_setup(input bit wide);
      int          r;
      int unsigned eff, span;
      logic [5:0]  plen;
      logic [9:0]  rows;
      logic [31:0] ivl;
      logic [63:0] f_net, l_net, low_mask, tmp;
      r = $urandom_range(0, 99);
      if (wide) plen = 6'($urandom_range(12, 32));
      else if (r < 10) plen = 6'd0;
      else if (r < 20) plen = 6'($urandom_range(33, 63));
      else plen = 6'($urandom_range(1, 32));
      eff       = (plen > 6'd32) ? 32 : int'(plen);
      net_shift = 32 - eff;
      net_max   = (64'd1 << eff) - 64'd1;
      low_mask  = (64'd1 << net_shift) - 64'd1;
      span      = wide ? $urandom_range(900, 1100) : $urandom_range(1, 100);
      if (wide) f_net = {32'd0, $urandom()} % (net_max - 64'd1100);
      else f_net = {32'd0, $urandom()} % (net_max + 64'd1);
      l_net = f_net + span - 64'd1;
      if (l_net > net_max) l_net = net_max;
      // Now and then reverse the range so the maps stay empty.
      if (!wide && $urandom_range(0, 9) == 0) begin
         tmp   = f_net;
         f_net = l_net;
         l_net = tmp;
      end
      lo_net = (f_net < l_net) ? f_net : l_net;
      hi_net = (f_net < l_net) ? l_net : f_net;
      r = $urandom_range(0, 99);
      if (r < 10) ivl = 32'd0;
      else if (r < 15) ivl = $urandom();
      else ivl = $urandom_range(1, 40);
      time_step = (ivl > 32'd40) ? 32'd1000 : ivl / 3 + 32'd2;
      if ($urandom_range(0, 4) == 0) rows = 10'($urandom_range(990, 1023));
      else rows = 10'($urandom_range(0, 6));
      // Upper data bits of the narrow registers are junk; the block must drop them.
      write_reg(REG_PREFIX_LEN, {26'($urandom()), plen});
      write_reg(REG_RANGE_FIRST, 32'((f_net << net_shift) | ({32'd0, $urandom()} & low_mask)));
      write_reg(REG_RANGE_LAST, 32'((l_net << net_shift) | ({32'd0, $urandom()} & low_mask)));
      write_reg(REG_INTERVAL, ivl);
      write_reg(REG_WINDOW_ROWS, {22'($urandom()), rows});
      csr_valid <= 1'b0;
   endtask

   // Mostly in-order flow records in range; some end items and raw noise.
   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         send_request(KIND_END, $urandom(), $urandom(), $urandom());
      end else if (r < 20) begin
         send_request(KIND_FLOW, $urandom(), $urandom(), $urandom());
      end else begin
         tb_now = tb_now + $urandom_range(0, time_step);
         send_request(KIND_FLOW, pick_addr(), pick_addr(), tb_now);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_FLOW;
      req_src_addr = '0;
      req_dst_addr = '0;
      req_seconds  = '0;
      rsp_ready    = 1'b0;
      rsp_hold     = 0;
      csr_valid    = 1'b0;
      csr_index    = REG_RANGE_FIRST;
      csr_wdata    = '0;
      req_steady   = 1'b0;
      rsp_steady   = 1'b0;
      quiet_cycles = 0;
      lo_net       = '0;
      hi_net       = '0;
      net_max      = '0;
      net_shift    = 0;
      tb_now       = '0;
      time_step    = 32'd1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: range of 255 networks at /8, four words per map.
      // End item before any record: empty maps, row zero.
      send_request(KIND_END, '1, '1, '1);
      idle_req();
      // First record fixes the interval start; first and last map entries.
      send_request(KIND_FLOW, 32'h0100_0000, 32'hFFFF_FFFF, 32'd100);
      idle_req();
      // Both addresses just below the range; time exactly at the interval end.
      send_request(KIND_FLOW, 32'h00FF_FFFF, 32'h0000_0000, 32'd400);
      idle_req();
      // One second past the interval end: flush first, then mark.
      send_request(KIND_FLOW, 32'hFF00_0000, 32'h8012_3456, 32'd401);
      idle_req();
      // Time behind the interval start never flushes.
      send_request(KIND_FLOW, 32'h0A0A_0A0A, 32'h0A0B_0C0D, 32'd0);
      idle_req();
      send_request(KIND_END, $urandom(), $urandom(), $urandom());
      idle_req();
      send_request(KIND_END, 32'h0, 32'h0, 32'h0);
      idle_req();
      send_request(KIND_FLOW, 32'h7FFF_FFFF, 32'h55AA_55AA, 32'hFFFF_FFFF);
      settle();

      // Range too wide: no shift, whole address space, size saturates.
      write_reg(REG_PREFIX_LEN, 32'd32);
      write_reg(REG_RANGE_FIRST, 32'h0);
      write_reg(REG_RANGE_LAST, 32'hFFFF_FFFF);
      write_reg(REG_INTERVAL, 32'd0);
      write_reg(REG_WINDOW_ROWS, 32'd1);
      csr_valid <= 1'b0;
      send_request(KIND_FLOW, 32'd0, 32'd1023, 32'd5);
      idle_req();
      // Indexes past the map size are dropped.
      send_request(KIND_FLOW, 32'd1024, 32'hFFFF_FFFF, 32'd700);
      idle_req();
      send_request(KIND_FLOW, 32'd64, 32'd63, 32'd701);
      idle_req();
      send_request(KIND_FLOW, 32'h3FF, 32'h200, 32'd701);
      idle_req();
      send_request(KIND_END, $urandom(), $urandom(), $urandom());
      settle();

      // Prefix length zero folds everything onto one entry; window zero.
      write_reg(REG_PREFIX_LEN, 32'd0);
      write_reg(REG_RANGE_FIRST, 32'hDEAD_BEEF);
      write_reg(REG_RANGE_LAST, 32'h1234_5678);
      write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
      write_reg(REG_WINDOW_ROWS, 32'd0);
      csr_valid <= 1'b0;
      // Start plus the largest interval must not wrap.
      send_request(KIND_FLOW, $urandom(), $urandom(), 32'hFFFF_FFFF);
      idle_req();
      send_request(KIND_END, $urandom(), $urandom(), $urandom());
      settle();

      // Prefix above 32 and a reversed range: flushes count but emit nothing.
      write_reg(REG_PREFIX_LEN, 32'd40);
      write_reg(REG_RANGE_FIRST, 32'h8000_0001);
      write_reg(REG_RANGE_LAST, 32'h8000_0000);
      write_reg(REG_INTERVAL, 32'd1);
      write_reg(REG_WINDOW_ROWS, 32'd1000);
      write_reg(REG_UNUSED, $urandom());
      csr_valid <= 1'b0;
      send_request(KIND_FLOW, 32'h8000_0000, 32'h8000_0001, 32'd702);
      idle_req();
      send_request(KIND_FLOW, 32'h8000_0001, 32'h8000_0000, 32'd703);
      idle_req();
      send_request(KIND_END, $urandom(), $urandom(), $urandom());
      settle();

      // Random rounds; the last one runs a wide map.
      tb_now = 32'd703;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         req_steady = (round == 1);
         rsp_steady = (round == 2);
         random_setup(round == RANDOM_ROUNDS - 1);
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            send_random_item();
            // Hold off now and then until every word is back.
            if (i == ROUND_ITEMS / 2 || $urandom_range(0, 29) == 0) wait_for_drain();
            else idle_req();
         end
         settle();
      end

      if (mismatch_count == 0 && words_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
